// ===== rtl/svr_pkg.sv =====
// Shared types, constants and the note frequency table for the sine voice.
package svr_pkg;

    localparam int NOTE_W        = 7;
    localparam int VEL_W         = 8;
    localparam int SEMI_W        = 4;
    localparam int OCT_W         = 4;
    localparam int RATE_W        = 18;
    localparam int LEVEL_W       = 16;
    localparam int GAIN_W        = 17;
    localparam int MAG_W         = 17;
    localparam int BASE_W        = 28;
    localparam int NUM_BITS      = 38;
    localparam int FREQ_SHIFT    = 24 + 5;
    localparam int NOTES_PER_OCT = 12;
    localparam int NUM_OCT       = 11;
    localparam int IN_DATA_W     = 16;
    localparam int CMD_W         = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [RATE_W-1:0]  RATE_RESET = 18'd48000;
    localparam logic [13:0]        LEVEL_Q16  = 14'd9830;
    localparam logic [15:0]        DECAY_Q16  = 16'd64881;
    localparam logic [GAIN_W-1:0]  FLOOR_Q16  = 17'd3277;
    localparam logic [GAIN_W-1:0]  GAIN_ONE   = 17'd65536;
    localparam logic [MAG_W-1:0]   SIN_A      = 17'd102944;
    localparam logic [MAG_W-1:0]   SIN_B      = 17'd42047;
    localparam logic [MAG_W-1:0]   SIN_C      = 17'd4640;

    typedef enum logic [CMD_W-1:0] {
        K_TICK = 2'd0,
        K_ON   = 2'd1,
        K_OFF  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [SEMI_W-1:0]   semi;
        logic [OCT_W-1:0]    oct;
        logic [VEL_W-1:0]    velocity;
        logic                allow_release;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic emitting;
    } t_bstat;

    // Lowest-octave note frequencies, Q24 Hz
    function automatic logic [BASE_W-1:0] base_freq(input logic [SEMI_W-1:0] semi);
        logic [BASE_W-1:0] f;
        case (semi)
            4'd0:    f = 28'd137167144;
            4'd1:    f = 28'd145323527;
            4'd2:    f = 28'd153964914;
            4'd3:    f = 28'd163120144;
            4'd4:    f = 28'd172819773;
            4'd5:    f = 28'd183096175;
            4'd6:    f = 28'd193983636;
            4'd7:    f = 28'd205518503;
            4'd8:    f = 28'd217739269;
            4'd9:    f = 28'd230686720;
            4'd10:   f = 28'd244404067;
            4'd11:   f = 28'd258937088;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/sine_voice_with_release_unit.sv =====
// Top level of the sine voice: input stage, command queue and voice engine.
//
// Input stream: tuser carries the command (tick, note on, note off; code 3 is dropped),
// tdata carries note, velocity and the release flag. Output stream: one item per tick,
// tdata is the signed sample, tuser the sounding flag. i_cfg_we writes the sample rate.
// Flow: the input stage registers an item, a two-entry queue buffers it, the engine
// runs it. A tick steps through S_SQ, S_P1, S_P2 and S_P3 (sine polynomial on the
// shared multiplier), then S_LVL, S_GAIN (gain chain), S_RND and S_EMIT; a silent
// voice goes straight to S_EMIT. A note-on runs the bit-serial phase step divider in
// S_DIV, then S_DFIN sets the step; a note-off is handled in S_IDLE.
// Up to three items can be held ahead of the engine, so the input keeps flowing while a
// result waits in the output register.
// Reset: synchronous, active low; voice idle, sample rate 48000, queue empty.
// When the output is stalled the engine holds in its final step; the queue then fills
// and s_axis_tready drops.
module sine_voice_with_release_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // note[6:0], velocity[14:7], allow_release[15]
    input  logic [svr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command[1:0]
    input  logic [svr_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample[SAMPLE_BITS-1:0], zero fill above
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // sounding[0]
    output logic [0:0]                        m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [svr_pkg::RATE_W-1:0]        i_cfg_wdata
);
    import svr_pkg::*;

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic                          w_push_valid;
    t_cmd                          w_push_data;
    logic                          w_push_ready;
    logic                          w_pop_valid;
    t_cmd                          w_pop_data;
    t_bstat                        w_bstat;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic                          w_sounding;

    svr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .o_push_valid (w_push_valid),
        .o_push_data  (w_push_data),
        .i_push_ready (w_push_ready)
    );

    svr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_data),
        .i_pop_ready  (w_bstat.idle)
    );

    svr_back #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop_valid (w_pop_valid),
        .i_pop_data  (w_pop_data),
        .o_stat      (w_bstat),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_sample    (w_sample),
        .o_sounding  (w_sounding)
    );

    assign m_axis_tdata = OUT_W'($unsigned(w_sample));
    assign m_axis_tuser = w_sounding;

    // a decoded item waiting on a full queue must not change or vanish
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_valid && !w_push_ready) |=> (w_push_valid && $stable(w_push_data)))
        else $error("front item changed while queue full");

    // new output items come only from the engine's final step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_bstat.emitting))
        else $error("output valid rose without an emit");

    // the engine takes a queued item only when one is there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bstat.idle && !w_pop_valid) |=> !(w_bstat.emitting))
        else $error("engine left idle without a queued item");

endmodule

// ===== rtl/svr_front.sv =====
// Input stage: takes items, decodes the command and splits the note into octave and semitone.
module svr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic [svr_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic [svr_pkg::CMD_W-1:0]     i_tuser,
    output logic                          o_push_valid,
    output svr_pkg::t_cmd                 o_push_data,
    input  logic                          i_push_ready
);
    import svr_pkg::*;

    logic                r_valid, n_valid;
    t_cmd                r_cmd, n_cmd;
    logic [NOTE_W-1:0]   w_note;
    logic [OCT_W-1:0]    w_oct;
    logic [SEMI_W-1:0]   w_semi;
    logic                w_known;
    logic                w_accept;

    assign w_note   = i_tdata[NOTE_W-1:0];
    assign o_tready = !r_valid || i_push_ready;
    assign w_accept = i_tvalid && o_tready;

    always_comb begin
        w_oct = '0;
        for (int k = 1; k < NUM_OCT; k++) begin
            if (w_note >= NOTE_W'(NOTES_PER_OCT * k)) begin
                w_oct = OCT_W'(k);
            end
        end
        w_semi = SEMI_W'(w_note - NOTE_W'(NOTES_PER_OCT) * NOTE_W'(w_oct));
    end

    always_comb begin
        case (i_tuser)
            K_TICK, K_ON, K_OFF: w_known = 1'b1;
            default:             w_known = 1'b0;
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_cmd   = r_cmd;
        if (w_accept) begin
            n_valid             = w_known;
            n_cmd.kind          = t_kind'(i_tuser);
            n_cmd.semi          = w_semi;
            n_cmd.oct           = w_oct;
            n_cmd.velocity      = i_tdata[NOTE_W +: VEL_W];
            n_cmd.allow_release = i_tdata[NOTE_W + VEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_cmd;

endmodule

// ===== rtl/svr_queue.sv =====
// Two-entry command queue between the input stage and the voice engine.
module svr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  svr_pkg::t_cmd i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output svr_pkg::t_cmd o_pop_data,
    input  logic          i_pop_ready
);
    import svr_pkg::*;

    t_cmd                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 w_push, w_pop;

    assign o_push_ready = r_cnt != Q_CNT_W'(Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/svr_back.sv =====
// Voice engine: phase step divider, sine polynomial, gain chain, release and output register.
module svr_back #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [svr_pkg::RATE_W-1:0] i_cfg_wdata,
    input  logic                       i_pop_valid,
    input  svr_pkg::t_cmd              i_pop_data,
    output svr_pkg::t_bstat            o_stat,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                       o_sounding
);
    import svr_pkg::*;

    localparam int DEN_W   = RATE_W + FREQ_SHIFT;
    localparam int CNT_W   = $clog2(NUM_BITS + PHASE_BITS + 1);
    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int ZSH     = 16 - QB;
    localparam int MUL_W   = 2 * MAG_W;
    localparam int PROD1_W = MAG_W + LEVEL_W;
    localparam int PROD_W  = PROD1_W + GAIN_W;
    localparam int SH      = 49 - SAMPLE_BITS;
    localparam int RND_W   = PROD_W - SH + 1;
    localparam logic [QB:0]       QUARTER = (QB + 1)'(1 << QB);
    localparam logic [RND_W-1:0]  HI_POS  = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [RND_W-1:0]  HI_NEG  = RND_W'(1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] SAT_POS = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_NEG = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_DIV  = 11'b00000000010,
        S_DFIN = 11'b00000000100,
        S_SQ   = 11'b00000001000,
        S_P1   = 11'b00000010000,
        S_P2   = 11'b00000100000,
        S_P3   = 11'b00001000000,
        S_LVL  = 11'b00010000000,
        S_GAIN = 11'b00100000000,
        S_RND  = 11'b01000000000,
        S_EMIT = 11'b10000000000
    } t_state;

    t_state                   r_state, n_state;
    logic [RATE_W-1:0]        r_rate;
    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [PHASE_BITS-1:0]    r_step, n_step;
    logic [LEVEL_W-1:0]       r_level, n_level;
    logic [GAIN_W-1:0]        r_gain, n_gain;
    logic                     r_silent, n_silent;
    logic                     r_neg, n_neg;
    logic [MAG_W-1:0]         r_z, n_z;
    logic [MAG_W-1:0]         r_z2, n_z2;
    logic [MAG_W-1:0]         r_t, n_t;
    logic [GAIN_W-1:0]        r_gdec, n_gdec;
    logic [PROD1_W-1:0]       r_prod1, n_prod1;
    logic [PROD_W-1:0]        r_prod2, n_prod2;
    logic [RND_W-1:0]         r_rnd, n_rnd;
    logic [NUM_BITS-1:0]      r_num, n_num;
    logic [DEN_W-1:0]         r_rem, n_rem;
    logic [PHASE_BITS-1:0]    r_q, n_q;
    logic                     r_sat, n_sat;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]   r_out_sample, n_out_sample;
    logic                     r_out_sounding, n_out_sounding;

    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]               w_quad;
    logic [QB:0]              w_j, w_jj;
    logic [MAG_W-1:0]         w_z;
    logic [MAG_W-1:0]         w_mul_a, w_mul_b;
    logic [MUL_W-1:0]         w_mul;
    logic [MAG_W-1:0]         w_mul_hi;
    logic [GAIN_W+15:0]       w_gd;
    logic [LEVEL_W+VEL_W-1:0] w_lv;
    logic [GAIN_W-1:0]        w_gsel;
    logic [PROD_W:0]          w_rsum;
    logic [RATE_W-1:0]        w_rate_nz;
    logic [DEN_W-1:0]         w_den;
    logic                     w_bit;
    logic [DEN_W:0]           w_rsh;
    logic                     w_ge;
    logic                     w_out_free;
    logic                     w_stop;

    // quarter-wave argument from the top phase bits
    assign w_idx  = r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign w_quad = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_j    = {1'b0, w_idx[QB-1:0]};
    assign w_jj   = w_quad[0] ? QUARTER - w_j : w_j;
    assign w_z    = MAG_W'(w_jj) << ZSH;

    // shared multiplier for the sine polynomial
    always_comb begin
        case (r_state)
            S_SQ: begin
                w_mul_a = r_z;
                w_mul_b = r_z;
            end
            S_P1: begin
                w_mul_a = SIN_C;
                w_mul_b = r_z2;
            end
            S_P2: begin
                w_mul_a = r_t;
                w_mul_b = r_z2;
            end
            default: begin
                w_mul_a = r_t;
                w_mul_b = r_z;
            end
        endcase
    end
    assign w_mul    = MUL_W'(w_mul_a) * MUL_W'(w_mul_b);
    assign w_mul_hi = w_mul[16 +: MAG_W];

    assign w_gd   = (GAIN_W + 16)'(r_gain) * (GAIN_W + 16)'(DECAY_Q16);
    assign w_lv   = (LEVEL_W + VEL_W)'(LEVEL_Q16) * (LEVEL_W + VEL_W)'(i_pop_data.velocity);
    assign w_gsel = (r_gain == '0) ? GAIN_ONE : r_gain;
    assign w_rsum = (PROD_W + 1)'(r_prod2) + ((PROD_W + 1)'(1) << (SH - 1));

    // restoring divider, one quotient bit per cycle
    assign w_rate_nz = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign w_den     = DEN_W'(w_rate_nz) << FREQ_SHIFT;
    assign w_bit     = (r_cnt > CNT_W'(PHASE_BITS)) ? r_num[NUM_BITS-1] : 1'b0;
    assign w_rsh     = {r_rem, w_bit};
    assign w_ge      = w_rsh >= {1'b0, w_den};

    assign w_out_free = !r_out_valid || i_tready;
    assign w_stop     = (r_gain != '0) && (r_gdec < FLOOR_Q16);

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_step         = r_step;
        n_level        = r_level;
        n_gain         = r_gain;
        n_silent       = r_silent;
        n_neg          = r_neg;
        n_z            = r_z;
        n_z2           = r_z2;
        n_t            = r_t;
        n_gdec         = r_gdec;
        n_prod1        = r_prod1;
        n_prod2        = r_prod2;
        n_rnd          = r_rnd;
        n_num          = r_num;
        n_rem          = r_rem;
        n_q            = r_q;
        n_sat          = r_sat;
        n_cnt          = r_cnt;
        n_out_valid    = r_out_valid && !i_tready;
        n_out_sample   = r_out_sample;
        n_out_sounding = r_out_sounding;

        case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    case (i_pop_data.kind)
                        K_ON: begin
                            n_phase = '0;
                            n_gain  = '0;
                            n_level = w_lv[7 +: LEVEL_W];
                            n_num   = NUM_BITS'(base_freq(i_pop_data.semi)) << i_pop_data.oct;
                            n_rem   = '0;
                            n_q     = '0;
                            n_sat   = 1'b0;
                            n_cnt   = CNT_W'(NUM_BITS + PHASE_BITS);
                            n_state = S_DIV;
                        end
                        K_OFF: begin
                            if (i_pop_data.allow_release) begin
                                if (r_gain == '0) begin
                                    n_gain = GAIN_ONE;
                                end
                            end else begin
                                n_step = '0;
                            end
                        end
                        K_TICK: begin
                            n_silent = r_step == '0;
                            n_z      = w_z;
                            n_neg    = w_quad[1];
                            n_state  = (r_step == '0) ? S_EMIT : S_SQ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_num = r_num << 1;
                n_rem = w_ge ? DEN_W'(w_rsh - {1'b0, w_den}) : DEN_W'(w_rsh);
                n_q   = {r_q[PHASE_BITS-2:0], w_ge};
                if (w_ge && (r_cnt > CNT_W'(PHASE_BITS))) begin
                    n_sat = 1'b1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                if (r_sat) begin
                    n_step = '1;
                end else if (r_q == '0) begin
                    n_step = PHASE_BITS'(1);
                end else begin
                    n_step = r_q;
                end
                n_state = S_IDLE;
            end
            S_SQ: begin
                n_z2    = w_mul_hi;
                n_state = S_P1;
            end
            S_P1: begin
                n_t     = SIN_B - w_mul_hi;
                n_state = S_P2;
            end
            S_P2: begin
                n_t     = SIN_A - w_mul_hi;
                n_state = S_P3;
            end
            S_P3: begin
                n_t     = w_mul_hi;
                n_state = S_LVL;
            end
            S_LVL: begin
                n_prod1 = PROD1_W'(r_t) * PROD1_W'(r_level);
                n_gdec  = w_gd[16 +: GAIN_W];
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_prod2 = PROD_W'(r_prod1) * PROD_W'(w_gsel);
                n_state = S_RND;
            end
            S_RND: begin
                n_rnd   = w_rsum[PROD_W:SH];
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_silent) begin
                        n_out_sample   = '0;
                        n_out_sounding = 1'b0;
                    end else begin
                        if (r_neg) begin
                            n_out_sample = (r_rnd > HI_NEG) ? SAT_NEG
                                         : SAMPLE_BITS'(-r_rnd[SAMPLE_BITS-1:0]);
                        end else begin
                            n_out_sample = (r_rnd > HI_POS) ? SAT_POS
                                         : r_rnd[SAMPLE_BITS-1:0];
                        end
                        n_phase        = r_phase + r_step;
                        n_out_sounding = !w_stop;
                        if (w_stop) begin
                            n_step = '0;
                            n_gain = '0;
                        end else if (r_gain != '0) begin
                            n_gain = r_gdec;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_phase     <= '0;
            r_step      <= '0;
            r_level     <= '0;
            r_gain      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rate      <= i_cfg_we ? i_cfg_wdata : r_rate;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_level     <= n_level;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
        r_silent       <= n_silent;
        r_neg          <= n_neg;
        r_z            <= n_z;
        r_z2           <= n_z2;
        r_t            <= n_t;
        r_gdec         <= n_gdec;
        r_prod1        <= n_prod1;
        r_prod2        <= n_prod2;
        r_rnd          <= n_rnd;
        r_num          <= n_num;
        r_rem          <= n_rem;
        r_q            <= n_q;
        r_sat          <= n_sat;
        r_cnt          <= n_cnt;
        r_out_sample   <= n_out_sample;
        r_out_sounding <= n_out_sounding;
    end

    assign o_stat.idle     = r_state == S_IDLE;
    assign o_stat.emitting = (r_state == S_EMIT) && w_out_free;
    assign o_tvalid        = r_out_valid;
    assign o_sample        = r_out_sample;
    assign o_sounding      = r_out_sounding;

endmodule
